### hdl/yuvrgb_pkg.sv
package yuvrgb_pkg;

   localparam int unsigned BYTE_W     = 8;
   localparam int unsigned CSR_ADDR_W = 2;
   localparam int unsigned CSR_DATA_W = 1;
   localparam int unsigned REQ_DATA_W = 8 * BYTE_W;
   localparam int unsigned RSP_DATA_W = 4 * BYTE_W;

   // register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_DIFFERENTIAL_MODE = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_COLOUR_CONVERT    = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_ALPHA_PRESENT     = 2'd2;

   typedef struct packed {
      logic differential_mode;
      logic colour_convert;
      logic alpha_present;
   } cfg_type;

   typedef struct packed {
      logic        [BYTE_W-1:0] luma;
      logic signed [BYTE_W-1:0] chroma_u;
      logic signed [BYTE_W-1:0] chroma_v;
      logic        [BYTE_W-1:0] alpha_in;
      logic        [BYTE_W-1:0] prev_blue;
      logic        [BYTE_W-1:0] prev_green;
      logic        [BYTE_W-1:0] prev_red;
      logic        [BYTE_W-1:0] prev_alpha;
   } pix_in_type;

   typedef struct packed {
      logic [BYTE_W-1:0] blue;
      logic [BYTE_W-1:0] green;
      logic [BYTE_W-1:0] red;
      logic [BYTE_W-1:0] alpha;
   } pix_out_type;

endpackage

### hdl/yuvrgb_csr.sv
module yuvrgb_csr import yuvrgb_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type               cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_addr)
            CSR_DIFFERENTIAL_MODE: cfg_in.differential_mode = csr_wdata[0];
            CSR_COLOUR_CONVERT:    cfg_in.colour_convert    = csr_wdata[0];
            CSR_ALPHA_PRESENT:     cfg_in.alpha_present     = csr_wdata[0];
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.differential_mode <= 1'b0;
         cfg_ff.colour_convert    <= 1'b1;
         cfg_ff.alpha_present     <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### hdl/yuvrgb_convert.sv
module yuvrgb_convert import yuvrgb_pkg::*; (
   input  cfg_type     cfg,
   input  pix_in_type  pix_in,
   output pix_out_type pix_out
);

   // clamp a signed 12-bit sum to 0..255
   function automatic logic [BYTE_W-1:0] clamp12(input logic signed [11:0] x);
      logic [BYTE_W-1:0] r;
      if (x[11]) begin
         r = '0;
      end else if (x[10:8] != 3'd0) begin
         r = '1;
      end else begin
         r = x[7:0];
      end
      return r;
   endfunction

   // clamp(prev + 2 * delta)
   function automatic logic [BYTE_W-1:0] restore(input logic [BYTE_W-1:0] prev,
                                                 input logic [BYTE_W-1:0] delta);
      logic signed [11:0] sum;
      sum = signed'({4'b0, prev}) + signed'({{3{delta[7]}}, delta, 1'b0});
      return clamp12(sum);
   endfunction

   logic signed [11:0] u_x, v_x;
   logic signed [11:0] t_b, t_g, t_r;
   logic signed [11:0] base_x;
   logic        [BYTE_W-1:0] base;
   logic        [BYTE_W-1:0] c_b, c_g, c_r;
   logic        [BYTE_W-1:0] d_b, d_g, d_r;

   assign u_x = {{4{pix_in.chroma_u[7]}}, pix_in.chroma_u};
   assign v_x = {{4{pix_in.chroma_v[7]}}, pix_in.chroma_v};

   assign t_b = (u_x * 12'sd7) >>> 2;
   assign t_g = (u_x * 12'sd3 + v_x * 12'sd6) >>> 3;
   assign t_r = (v_x * 12'sd3) >>> 1;

   // signed luma plus 128 is the byte with its top bit flipped
   assign base   = cfg.differential_mode ? {~pix_in.luma[7], pix_in.luma[6:0]}
                                         : pix_in.luma;
   assign base_x = signed'({4'b0, base});

   assign c_b = clamp12(base_x + t_b);
   assign c_g = clamp12(base_x - t_g);
   assign c_r = clamp12(base_x + t_r);

   // deltas: clamped byte minus 128, or raw samples
   assign d_b = cfg.colour_convert ? {~c_b[7], c_b[6:0]} : pix_in.luma;
   assign d_g = cfg.colour_convert ? {~c_g[7], c_g[6:0]} : pix_in.chroma_u;
   assign d_r = cfg.colour_convert ? {~c_r[7], c_r[6:0]} : pix_in.chroma_v;

   always_comb begin
      if (cfg.differential_mode) begin
         pix_out.blue  = restore(pix_in.prev_blue,  d_b);
         pix_out.green = restore(pix_in.prev_green, d_g);
         pix_out.red   = restore(pix_in.prev_red,   d_r);
         pix_out.alpha = cfg.alpha_present ? restore(pix_in.prev_alpha, pix_in.alpha_in)
                                           : pix_in.prev_alpha;
      end else begin
         pix_out.blue  = cfg.colour_convert ? c_b : pix_in.luma;
         pix_out.green = cfg.colour_convert ? c_g : pix_in.chroma_u;
         pix_out.red   = cfg.colour_convert ? c_r : pix_in.chroma_v;
         pix_out.alpha = cfg.alpha_present ? pix_in.alpha_in : pix_in.prev_alpha;
      end
   end

endmodule

### hdl/yuv_to_rgb_delta_pixel.sv
// a req beat goes through the input register, then the result register, to the rsp port
// one pixel per cycle while rsp_tready is high, via the single conversion pass between registers
// rsp_tready low stalls the result register; req_tready drops only when both stages are full
// reset: synchronous, active high; clears both stage valids and loads the config defaults
// (differential_mode 0, colour_convert 1, alpha_present 0)
module yuv_to_rgb_delta_pixel import yuvrgb_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   // input pixel stream
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // luma, chroma_u, chroma_v, alpha_in, prev_blue, prev_green, prev_red, prev_alpha
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // result pixel stream
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // blue, green, red, alpha
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // config write port
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type     cfg;
   pix_in_type  pix_in_ff;
   pix_in_type  pix_in_in;
   logic        in_valid_ff;
   logic        in_valid_in;
   pix_out_type pix_out;
   pix_out_type rsp_ff;
   logic        rsp_valid_ff;
   logic        rsp_valid_in;
   logic        rsp_load;
   logic        req_beat;

   yuvrgb_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // unpack the request beat, luma in the lowest byte
   always_comb begin
      pix_in_in.luma       = req_tdata[7:0];
      pix_in_in.chroma_u   = req_tdata[15:8];
      pix_in_in.chroma_v   = req_tdata[23:16];
      pix_in_in.alpha_in   = req_tdata[31:24];
      pix_in_in.prev_blue  = req_tdata[39:32];
      pix_in_in.prev_green = req_tdata[47:40];
      pix_in_in.prev_red   = req_tdata[55:48];
      pix_in_in.prev_alpha = req_tdata[63:56];
   end

   // result register can take a new pixel when empty or being drained
   assign rsp_load    = !rsp_valid_ff || rsp_tready;
   // input register frees when its pixel moves on
   assign req_tready  = !in_valid_ff || rsp_load;
   assign req_beat    = req_tvalid && req_tready;

   assign in_valid_in  = req_beat ? 1'b1 : (rsp_load ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = rsp_load ? in_valid_ff : rsp_valid_ff;

   yuvrgb_convert u_convert (
      .cfg     (cfg),
      .pix_in  (pix_in_ff),
      .pix_out (pix_out)
   );

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      if (req_beat) begin
         pix_in_ff <= pix_in_in;
      end
      if (rsp_load && in_valid_ff) begin
         rsp_ff <= pix_out;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_ff.alpha, rsp_ff.red, rsp_ff.green, rsp_ff.blue};

endmodule

### tb/yuv_to_rgb_delta_pixel_test.sv
module yuv_to_rgb_delta_pixel_test import yuvrgb_pkg::*; ();

   timeunit 1ns;
   timeprecision 1ps;

   // index past the last register, writes to it must change nothing
   localparam logic [CSR_ADDR_W-1:0] CSR_UNUSED = 2'd3;
   localparam int unsigned ITEMS_PER_PHASE = 50;

   // receiver stall patterns
   typedef enum int unsigned {
      READY_ALWAYS,
      READY_COIN,
      READY_SPARSE,
      READY_PERIODIC
   } stall_mode_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   // luma, chroma_u, chroma_v, alpha_in, prev_blue, prev_green, prev_red, prev_alpha
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b1;
   // blue, green, red, alpha
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_we     = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr   = CSR_DIFFERENTIAL_MODE;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;

   // register values as the block should hold them
   cfg_type        csr_shadow  = '{differential_mode: 1'b0, colour_convert: 1'b1,
                                   alpha_present: 1'b0};
   // result pixels still owed by the block, oldest first
   pix_out_type    expected_pixels[$];
   int unsigned    error_count = 0;
   int unsigned    burst_left  = 0;
   int unsigned    stall_cycle = 0;
   stall_mode_type stall_mode  = READY_ALWAYS;

   yuv_to_rgb_delta_pixel u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #10 clock = ~clock;

   // ------------------------------------------------------------------
   // pixel predictor
   // ------------------------------------------------------------------

   function automatic int clip_byte(input int x);
      return (x < 0) ? 0 : ((x > 255) ? 255 : x);
   endfunction

   function automatic pix_out_type convert_pixel(input pix_in_type p, input cfg_type c);
      int          y_u, y_s, u, v, a_s;
      int          b_c, g_c, r_c;
      pix_out_type o;
      y_u = int'(p.luma);
      y_s = int'(signed'(p.luma));
      u   = int'(p.chroma_u);
      v   = int'(p.chroma_v);
      a_s = int'(signed'(p.alpha_in));
      if (c.differential_mode) begin
         // signed deltas, biased by 128 around the clamp when converting
         if (c.colour_convert) begin
            b_c = clip_byte(y_s + ((7 * u) >>> 2) + 128) - 128;
            g_c = clip_byte(y_s - ((3 * u + 6 * v) >>> 3) + 128) - 128;
            r_c = clip_byte(y_s + ((3 * v) >>> 1) + 128) - 128;
         end else begin
            b_c = y_s;
            g_c = u;
            r_c = v;
         end
         o.blue  = 8'(clip_byte(int'(p.prev_blue) + 2 * b_c));
         o.green = 8'(clip_byte(int'(p.prev_green) + 2 * g_c));
         o.red   = 8'(clip_byte(int'(p.prev_red) + 2 * r_c));
         o.alpha = c.alpha_present ? 8'(clip_byte(int'(p.prev_alpha) + 2 * a_s))
                                   : p.prev_alpha;
      end else begin
         if (c.colour_convert) begin
            o.blue  = 8'(clip_byte(y_u + ((7 * u) >>> 2)));
            o.green = 8'(clip_byte(y_u - ((3 * u + 6 * v) >>> 3)));
            o.red   = 8'(clip_byte(y_u + ((3 * v) >>> 1)));
         end else begin
            o.blue  = p.luma;
            o.green = p.chroma_u;
            o.red   = p.chroma_v;
         end
         o.alpha = c.alpha_present ? p.alpha_in : p.prev_alpha;
      end
      return o;
   endfunction

   // ------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------

   function automatic pix_in_type make_pixel(
      input logic [7:0] y, u, v, a, pb, pg, pr, pa);
      pix_in_type p;
      p.luma       = y;
      p.chroma_u   = u;
      p.chroma_v   = v;
      p.alpha_in   = a;
      p.prev_blue  = pb;
      p.prev_green = pg;
      p.prev_red   = pr;
      p.prev_alpha = pa;
      return p;
   endfunction

   // half uniform bytes, half the edges of both signed and unsigned ranges
   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 7))
         0: return 8'h00;
         1: return 8'hFF;
         2: return 8'h7F;
         3: return 8'h80;
         default: return 8'($urandom);
      endcase
   endfunction

   task automatic report_error(input string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      error_count++;
   endtask

   // one config register write, enable dropped on the next falling edge
   task automatic write_csr(input logic [CSR_ADDR_W-1:0] addr, input logic val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= val;
      @(posedge clock);
      case (addr)
         CSR_DIFFERENTIAL_MODE: csr_shadow.differential_mode = val;
         CSR_COLOUR_CONVERT:    csr_shadow.colour_convert    = val;
         CSR_ALPHA_PRESENT:     csr_shadow.alpha_present     = val;
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // sends one pixel beat; the sender runs in bursts with random gaps between them
   task automatic send_pixel(input pix_in_type p);
      int unsigned gap;
      @(negedge clock);
      if (burst_left == 0) begin
         if ($urandom_range(0, 3) == 0) begin
            // long stretch with no idling at all
            burst_left = $urandom_range(40, 120);
            gap        = 0;
         end else begin
            burst_left = $urandom_range(1, 8);
            gap        = $urandom_range(1, 6);
         end
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {p.prev_alpha, p.prev_red, p.prev_green, p.prev_blue,
                     p.alpha_in, p.chroma_v, p.chroma_u, p.luma};
      do @(posedge clock); while (!req_tready);
      expected_pixels.push_back(convert_pixel(p, csr_shadow));
      burst_left--;
   endtask

   // stop sending and let every owed result come out
   task automatic wait_idle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
      // two register stages, plus margin
      repeat (4) @(posedge clock);
   endtask

   // ------------------------------------------------------------------
   // receiver stall pattern, independent of the sender
   // ------------------------------------------------------------------

   always @(negedge clock) begin
      stall_cycle++;
      if (stall_cycle % 97 == 0) begin
         stall_mode = stall_mode_type'($urandom_range(0, 3));
      end
      case (stall_mode)
         READY_ALWAYS:   rsp_tready <= 1'b1;
         READY_COIN:     rsp_tready <= ($urandom_range(0, 1) == 1);
         READY_SPARSE:   rsp_tready <= ($urandom_range(0, 3) == 0);
         default:        rsp_tready <= stall_cycle[2];
      endcase
   end

   // ------------------------------------------------------------------
   // result checker: each result beat against the oldest expectation
   // ------------------------------------------------------------------

   always @(posedge clock) begin
      pix_out_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_pixels.size() == 0) begin
            report_error($sformatf("unexpected result beat 0x%08h", rsp_tdata));
         end else begin
            want = expected_pixels.pop_front();
            if (rsp_tdata[7:0] !== want.blue)
               report_error($sformatf("blue got %02h want %02h", rsp_tdata[7:0], want.blue));
            if (rsp_tdata[15:8] !== want.green)
               report_error($sformatf("green got %02h want %02h", rsp_tdata[15:8], want.green));
            if (rsp_tdata[23:16] !== want.red)
               report_error($sformatf("red got %02h want %02h", rsp_tdata[23:16], want.red));
            if (rsp_tdata[31:24] !== want.alpha)
               report_error($sformatf("alpha got %02h want %02h", rsp_tdata[31:24], want.alpha));
         end
      end
   end

   // ------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------

   // reset defaults: absolute output, conversion on, no alpha channel
   task automatic test_reset_defaults();
      // clamp at zero and at 255, zero chroma, floor of small negatives
      send_pixel(make_pixel(8'h00, 8'h80, 8'h80, 8'h5A, 8'h11, 8'h22, 8'h33, 8'hC4));
      send_pixel(make_pixel(8'hFF, 8'h7F, 8'h7F, 8'hA5, 8'hEE, 8'hDD, 8'hCC, 8'h3B));
      send_pixel(make_pixel(8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
      send_pixel(make_pixel(8'h10, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
      send_pixel(make_pixel(8'hFF, 8'h80, 8'h7F, 8'h01, 8'h80, 8'h7F, 8'h01, 8'h80));
      wait_idle();
   endtask

   // absolute mode with alpha pass-through, then raw samples with conversion off
   task automatic test_absolute_alpha();
      write_csr(CSR_ALPHA_PRESENT, 1'b1);
      send_pixel(make_pixel(8'h40, 8'h20, 8'hE0, 8'h00, 8'h12, 8'h34, 8'h56, 8'hFF));
      send_pixel(make_pixel(8'hC0, 8'hE0, 8'h20, 8'hFF, 8'h12, 8'h34, 8'h56, 8'h00));
      wait_idle();
      write_csr(CSR_COLOUR_CONVERT, 1'b0);
      send_pixel(make_pixel(8'hFF, 8'h80, 8'h7F, 8'h3C, 8'h00, 8'h00, 8'h00, 8'h00));
      send_pixel(make_pixel(8'h00, 8'hFF, 8'h01, 8'hC3, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
      wait_idle();
   endtask

   // delta restore: saturation both ways, inner clamp of the signed deltas
   task automatic test_differential();
      write_csr(CSR_DIFFERENTIAL_MODE, 1'b1);
      write_csr(CSR_COLOUR_CONVERT, 1'b1);
      send_pixel(make_pixel(8'h7F, 8'h7F, 8'h7F, 8'h7F, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
      send_pixel(make_pixel(8'h80, 8'h80, 8'h80, 8'h80, 8'h00, 8'h00, 8'h00, 8'h00));
      send_pixel(make_pixel(8'h00, 8'h00, 8'h00, 8'h00, 8'h80, 8'h80, 8'h80, 8'h80));
      send_pixel(make_pixel(8'h7F, 8'h80, 8'h7F, 8'h01, 8'h40, 8'h40, 8'h40, 8'h40));
      send_pixel(make_pixel(8'h81, 8'h05, 8'hF9, 8'hFF, 8'h01, 8'hFE, 8'h7F, 8'h01));
      wait_idle();
      // raw samples used as deltas
      write_csr(CSR_COLOUR_CONVERT, 1'b0);
      send_pixel(make_pixel(8'h7F, 8'h80, 8'h01, 8'h80, 8'h80, 8'hFF, 8'h00, 8'hFF));
      send_pixel(make_pixel(8'h80, 8'h7F, 8'hFF, 8'h7F, 8'h7F, 8'h00, 8'hFF, 8'h00));
      send_pixel(make_pixel(8'hF0, 8'h10, 8'h00, 8'h00, 8'h20, 8'hE0, 8'h55, 8'hAA));
      wait_idle();
      // destination alpha untouched without an alpha channel
      write_csr(CSR_ALPHA_PRESENT, 1'b0);
      send_pixel(make_pixel(8'h30, 8'hD0, 8'h30, 8'h7F, 8'h90, 8'h70, 8'h50, 8'h00));
      send_pixel(make_pixel(8'hD0, 8'h30, 8'hD0, 8'h80, 8'h10, 8'h20, 8'h30, 8'hFF));
      wait_idle();
   endtask

   // a write past the last register index must leave the config alone
   task automatic test_unused_index();
      write_csr(CSR_UNUSED, 1'b1);
      send_pixel(make_pixel(8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA));
      send_pixel(make_pixel(8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55));
      wait_idle();
   endtask

   // every config combination once, then a couple of random ones
   task automatic test_random_pixels();
      int unsigned combo;
      for (int phase = 0; phase < 10; phase++) begin
         combo = (phase < 8) ? phase : $urandom_range(0, 7);
         write_csr(CSR_DIFFERENTIAL_MODE, combo[2]);
         write_csr(CSR_COLOUR_CONVERT, combo[1]);
         write_csr(CSR_ALPHA_PRESENT, combo[0]);
         repeat (ITEMS_PER_PHASE) begin
            send_pixel(make_pixel(pick_byte(), pick_byte(), pick_byte(), pick_byte(),
                                  pick_byte(), pick_byte(), pick_byte(), pick_byte()));
         end
         wait_idle();
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_absolute_alpha();
      test_differential();
      test_unused_index();
      test_random_pixels();
      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // hang guard
   initial begin
      #5_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule

### files.f
hdl/yuvrgb_pkg.sv
hdl/yuvrgb_csr.sv
hdl/yuvrgb_convert.sv
hdl/yuv_to_rgb_delta_pixel.sv
tb/yuv_to_rgb_delta_pixel_test.sv
